// ----- rtl/lca_pkg.sv -----
// ----------------------------------------------------------------------------
// lca_pkg: shared types and constants of the common ancestor engine
// field widths, request kinds and the control word of the lift step unit
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int NODE_W      = 16;
    localparam int DEPTH_W     = 16;
    localparam int DEF_NODES   = 65536;
    localparam int DEF_LEVELS  = 16;

    localparam logic KIND_ATTACH = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // what the table read issued last cycle is for
    typedef enum logic [1:0] {
        PK_NONE,
        PK_LIFT,
        PK_CLIMB
    } t_pend;

    typedef struct packed {
        t_pend pk;    // pending read kind
        logic  take;  // lift: depth difference bit of the pending level
        logic  za;    // port a read was issued for the sentinel node
        logic  zb;    // port b read was issued for the sentinel node
        logic  byp;   // port a read collided with the write of the same cycle
    } t_step_ctl;

endpackage

// ----- rtl/lca_ram.sv -----
// ----------------------------------------------------------------------------
// lca_ram: generic memory
// one write port, two read ports, registered read data (read before write)
// ----------------------------------------------------------------------------
module lca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/lca_step.sv -----
// ----------------------------------------------------------------------------
// lca_step: shared lift step unit
// cleans the table read data and picks the next pair of nodes
// ----------------------------------------------------------------------------
module lca_step #(
    parameter int NODES = lca_pkg::DEF_NODES
) (
    input  lca_pkg::t_step_ctl           i_ctl,
    input  logic [lca_pkg::NODE_W-1:0]   i_rdata_a,
    input  logic [lca_pkg::NODE_W-1:0]   i_rdata_b,
    input  logic [lca_pkg::NODE_W-1:0]   i_byp_data,
    input  logic [$clog2(NODES)-1:0]     i_a,
    input  logic [$clog2(NODES)-1:0]     i_b,
    output logic [$clog2(NODES)-1:0]     o_fa,
    output logic [$clog2(NODES)-1:0]     o_cur_a,
    output logic [$clog2(NODES)-1:0]     o_cur_b
);

    localparam int NW = $clog2(NODES);

    logic [lca_pkg::NODE_W-1:0] va;
    logic [NW-1:0]              fb;

    // sentinel row reads as zero, out of range entries map to the sentinel
    always_comb begin
        va = i_ctl.byp ? i_byp_data : i_rdata_a;
        o_fa = (i_ctl.za || (32'(va) >= NODES)) ? '0 : NW'(va);
        fb = (i_ctl.zb || (32'(i_rdata_b) >= NODES)) ? '0 : NW'(i_rdata_b);
    end

    always_comb begin
        o_cur_a = i_a;
        o_cur_b = i_b;
        case (i_ctl.pk)
            lca_pkg::PK_LIFT: begin
                if (i_ctl.take) begin
                    o_cur_a = o_fa;
                end
            end
            lca_pkg::PK_CLIMB: begin
                if (o_fa != fb) begin
                    o_cur_a = o_fa;
                    o_cur_b = fb;
                end
            end
            default: begin
                o_cur_a = i_a;
                o_cur_b = i_b;
            end
        endcase
    end

endmodule

// ----- rtl/lowest_common_ancestor_engine.sv -----
// ----------------------------------------------------------------------------
// lowest_common_ancestor_engine: binary lifting common ancestor engine
// attach requests build the tree, query requests return the common ancestor
// ----------------------------------------------------------------------------
// The block keeps a forest of up to NODES nodes in two memories: the depth of
// each node and, per node, its ancestors at distances 1, 2, 4 .. 2^(LEVELS-1).
// An attach request (tuser 0) links node_a under node_b (0 for a root); the
// parent must have been attached first. Attaching node 0, or a node number at
// or above NODES, is ignored; node numbers at or above NODES read as node 0.
// A query request (tuser 1) returns one result, the lowest common ancestor of
// node_a and node_b. Attach gives no result. One request is in work at a time
// and the slave side is not ready meanwhile. All table reads run one per cycle
// through the ancestor memory's registered read ports, each address taken
// from the data of the read before it, so that dependent chain sets the pace:
// a query shows its result in the same cycle as the slave side turns ready
// again, and a previous result the master side has not yet taken holds the
// query in its last step until it drains. No clearing pass is needed after
// reset; node 0 is handled as a fixed sentinel, and reading a node that was
// never attached gives an unspecified answer.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_engine #(
    parameter int NODES  = lca_pkg::DEF_NODES,
    parameter int LEVELS = lca_pkg::DEF_LEVELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] node_a, [31:16] node_b
    input  logic        i_s_tuser,   // [0] kind
    // result side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] ancestor_node
);

    localparam int NW     = $clog2(NODES);
    localparam int LW     = $clog2(LEVELS);
    localparam int TAW    = NW + LW;
    localparam int TDEPTH = NODES * (2 ** LW);
    localparam int DW     = lca_pkg::DEPTH_W;
    localparam int KW     = lca_pkg::NODE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AT_LOOP,   // one ancestor level per cycle
        S_Q_CMP,     // compare depths, deeper node goes to a
        S_LIFT,      // lift a by the depth difference
        S_CLIMB,     // lift both while ancestors differ
        S_FINAL,     // read parent of a
        S_RES,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [NW-1:0]       r_a, n_a;
    logic [NW-1:0]       r_b, n_b;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic                r_first, n_first;
    logic                r_zda, n_zda;
    logic                r_zdb, n_zdb;
    logic                r_same, n_same;
    logic [DW-1:0]       r_diff, n_diff;
    logic [KW-1:0]       r_byp_d, n_byp_d;
    lca_pkg::t_step_ctl  r_ctl, n_ctl;
    logic                r_out_valid, n_out_valid;
    logic [KW-1:0]       r_out_data, n_out_data;

    // memory ports
    logic                tbl_we;
    logic [TAW-1:0]      tbl_waddr, tbl_ra, tbl_rb;
    logic [KW-1:0]       tbl_wdata, tbl_rdata_a, tbl_rdata_b;
    logic                dep_we;
    logic [NW-1:0]       dep_waddr, dep_ra, dep_rb;
    logic [DW-1:0]       dep_wdata, dep_rdata_a, dep_rdata_b;

    // step unit
    logic [NW-1:0]       fa, cur_a, cur_b;

    // request fields, node numbers out of range become the sentinel
    logic                s_accept;
    logic [KW-1:0]       in_a, in_b;
    logic [NW-1:0]       a_idx, b_idx;
    logic [DW-1:0]       dva, dvb;
    logic                diff_bit;

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign in_a       = i_s_tdata[15:0];
    assign in_b       = i_s_tdata[31:16];
    assign a_idx      = (32'(in_a) < NODES) ? NW'(in_a) : '0;
    assign b_idx      = (32'(in_b) < NODES) ? NW'(in_b) : '0;

    // sentinel depth is zero
    assign dva = r_zda ? '0 : dep_rdata_a;
    assign dvb = r_zdb ? '0 : dep_rdata_b;

    // only the low LEVELS bits of the depth difference take part
    assign diff_bit = |((32'(r_diff) >> r_lvl) & 32'd1);

    lca_ram #(
        .WIDTH (KW),
        .DEPTH (TDEPTH)
    ) u_anc_ram (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_waddr   (tbl_waddr),
        .i_wdata   (tbl_wdata),
        .i_raddr_a (tbl_ra),
        .o_rdata_a (tbl_rdata_a),
        .i_raddr_b (tbl_rb),
        .o_rdata_b (tbl_rdata_b)
    );

    lca_ram #(
        .WIDTH (DW),
        .DEPTH (NODES)
    ) u_dep_ram (
        .i_clk     (i_clk),
        .i_we      (dep_we),
        .i_waddr   (dep_waddr),
        .i_wdata   (dep_wdata),
        .i_raddr_a (dep_ra),
        .o_rdata_a (dep_rdata_a),
        .i_raddr_b (dep_rb),
        .o_rdata_b (dep_rdata_b)
    );

    lca_step #(
        .NODES (NODES)
    ) u_step (
        .i_ctl      (r_ctl),
        .i_rdata_a  (tbl_rdata_a),
        .i_rdata_b  (tbl_rdata_b),
        .i_byp_data (r_byp_d),
        .i_a        (r_a),
        .i_b        (r_b),
        .o_fa       (fa),
        .o_cur_a    (cur_a),
        .o_cur_b    (cur_b)
    );

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_lvl       = r_lvl;
        n_first     = r_first;
        n_zda       = r_zda;
        n_zdb       = r_zdb;
        n_same      = r_same;
        n_diff      = r_diff;
        n_byp_d     = r_byp_d;
        n_ctl       = '0;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;

        tbl_we      = 1'b0;
        tbl_waddr   = '0;
        tbl_wdata   = '0;
        tbl_ra      = '0;
        tbl_rb      = '0;
        dep_we      = 1'b0;
        dep_waddr   = '0;
        dep_wdata   = '0;
        dep_ra      = '0;
        dep_rb      = '0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser == lca_pkg::KIND_QUERY) begin
                        // both depths in one read
                        dep_ra  = a_idx;
                        dep_rb  = b_idx;
                        n_zda   = (a_idx == '0);
                        n_zdb   = (b_idx == '0);
                        n_a     = a_idx;
                        n_b     = b_idx;
                        n_state = S_Q_CMP;
                    end else if (a_idx != '0) begin
                        // level 0 is the parent itself, start the doubling chain
                        tbl_we        = 1'b1;
                        tbl_waddr     = {a_idx, {LW{1'b0}}};
                        tbl_wdata     = KW'(b_idx);
                        tbl_ra        = {b_idx, {LW{1'b0}}};
                        dep_ra        = b_idx;
                        n_zda         = (b_idx == '0);
                        n_ctl.za      = (b_idx == '0);
                        n_ctl.byp     = (b_idx == a_idx);
                        n_byp_d       = KW'(b_idx);
                        n_a           = a_idx;
                        n_lvl         = '0;
                        n_first       = 1'b1;
                        n_state       = S_AT_LOOP;
                    end
                end
            end

            S_AT_LOOP: begin
                // fa is the ancestor at level r_lvl+1 of the attached node
                tbl_we    = 1'b1;
                tbl_waddr = {r_a, r_lvl + LW'(1)};
                tbl_wdata = KW'(fa);
                if (r_first) begin
                    dep_we    = 1'b1;
                    dep_waddr = r_a;
                    dep_wdata = dva + DW'(1);
                    n_first   = 1'b0;
                end
                if (r_lvl == LW'(LEVELS - 2)) begin
                    n_state = S_IDLE;
                end else begin
                    tbl_ra    = {fa, r_lvl + LW'(1)};
                    n_ctl.za  = (fa == '0);
                    n_ctl.byp = (fa == r_a);
                    n_byp_d   = KW'(fa);
                    n_lvl     = r_lvl + LW'(1);
                end
            end

            S_Q_CMP: begin
                if (dva < dvb) begin
                    n_a    = r_b;
                    n_b    = r_a;
                    n_diff = dvb - dva;
                end else begin
                    n_diff = dva - dvb;
                end
                n_lvl   = LW'(LEVELS - 1);
                n_state = S_LIFT;
            end

            S_LIFT: begin
                tbl_ra     = {cur_a, r_lvl};
                n_a        = cur_a;
                n_b        = cur_b;
                n_ctl.pk   = lca_pkg::PK_LIFT;
                n_ctl.take = diff_bit;
                n_ctl.za   = (cur_a == '0);
                if (r_lvl == '0) begin
                    n_lvl   = LW'(LEVELS - 1);
                    n_state = S_CLIMB;
                end else begin
                    n_lvl = r_lvl - LW'(1);
                end
            end

            S_CLIMB: begin
                tbl_ra   = {cur_a, r_lvl};
                tbl_rb   = {cur_b, r_lvl};
                n_a      = cur_a;
                n_b      = cur_b;
                n_ctl.pk = lca_pkg::PK_CLIMB;
                n_ctl.za = (cur_a == '0);
                n_ctl.zb = (cur_b == '0);
                if (r_lvl == '0) begin
                    n_state = S_FINAL;
                end else begin
                    n_lvl = r_lvl - LW'(1);
                end
            end

            S_FINAL: begin
                tbl_ra   = {cur_a, {LW{1'b0}}};
                n_ctl.za = (cur_a == '0);
                n_a      = cur_a;
                n_b      = cur_b;
                n_same   = (cur_a == cur_b);
                n_state  = S_RES;
            end

            S_RES: begin
                n_a     = r_same ? r_a : fa;
                n_state = S_OUT;
            end

            S_OUT: begin
                // wait for the result register to drain
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = KW'(r_a);
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ctl       <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ctl       <= n_ctl;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_lvl      <= n_lvl;
        r_zda      <= n_zda;
        r_zdb      <= n_zdb;
        r_same     <= n_same;
        r_diff     <= n_diff;
        r_byp_d    <= n_byp_d;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- rtl/lca_chk.sv -----
// ----------------------------------------------------------------------------
// lca_chk: port level checks of the common ancestor engine
// attached to the top level by the bind below
// ----------------------------------------------------------------------------
module lca_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    logic s_accept;

    assign s_accept = i_s_tvalid && o_s_tready;

    // a query keeps the request side closed while it works
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (i_s_tuser == lca_pkg::KIND_QUERY) |=> !o_s_tready)
        else $error("request accepted during a query");

    // an attach never raises a result
    a_attach_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (i_s_tuser == lca_pkg::KIND_ATTACH) |=> !$rose(o_m_tvalid))
        else $error("result raised by an attach");

    // a query result cannot appear right after the request
    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (i_s_tuser == lca_pkg::KIND_QUERY) |=> ##1 !$rose(o_m_tvalid))
        else $error("query result too early");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

bind lowest_common_ancestor_engine lca_chk u_lca_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- tb/sv/lowest_common_ancestor_engine_test.sv -----
// ----------------------------------------------------------------------------
// lowest_common_ancestor_engine_test: self-checking bench of the ancestor engine
// builds forests through attach requests, checks every query against a local
// binary lifting predictor, with random stalls on both stream sides
// ----------------------------------------------------------------------------
module lowest_common_ancestor_engine_test;

    localparam int LEVELS       = lca_pkg::DEF_LEVELS;
    localparam int NODES        = lca_pkg::DEF_NODES;
    // margin for the last request; an attach finishes sooner than a query result
    localparam int DRAIN_CYCLES = 2 * LEVELS + 8;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int RUN_LIMIT    = 4000000;

    typedef logic [lca_pkg::NODE_W-1:0] t_node;

    // one pending query: the two nodes asked about and the predicted answer
    typedef struct {
        t_node node_a;
        t_node node_b;
        t_node lca;
    } t_lca_due;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [15:0] node_a, [31:16] node_b
    logic        s_tuser  = 1'b0; // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] ancestor_node

    // predictor state: every 16-bit node number is in range at NODES = 65536,
    // unwritten entries stay zero, so the sentinel row and depth read as zero
    bit [lca_pkg::NODE_W-1:0]  ancestor_rows [NODES * LEVELS];
    bit [lca_pkg::DEPTH_W-1:0] depth_of [NODES];

    // nodes attached so far, queries and parents are picked from these
    t_node    placed [$];
    bit       is_placed [NODES];

    t_lca_due lca_due [$];
    t_lca_due got_due;
    int       fault_count = 0;
    int       ready_hold  = 0;
    bit       steady      = 1'b0;  // no idle gaps and no new stalls while set

    lowest_common_ancestor_engine #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // depth is parent depth plus one, row filled by doubling over its own row
    function automatic void record_attach(input t_node child, input t_node parent);
        int    base;
        t_node mid;
        if (child == '0) return;  // sentinel attach is ignored
        base = int'(child) * LEVELS;
        depth_of[child] = depth_of[parent] + 1'b1;
        ancestor_rows[base] = parent;
        for (int l = 0; l + 1 < LEVELS; l++) begin
            mid = ancestor_rows[base + l];
            ancestor_rows[base + l + 1] = ancestor_rows[int'(mid) * LEVELS + l];
        end
    endfunction

    // lift the deeper node to equal depth, then both while ancestors differ
    function automatic t_node predict_lca(input t_node na, input t_node nb);
        t_node x;
        t_node y;
        t_node px;
        t_node py;
        int    span;
        x = na;
        y = nb;
        if (depth_of[na] < depth_of[nb]) begin
            x = nb;
            y = na;
        end
        // only the low LEVELS bits of the depth difference take part
        span = int'(depth_of[x]) - int'(depth_of[y]);
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (((span >> l) & 1) != 0) x = ancestor_rows[int'(x) * LEVELS + l];
        end
        for (int l = LEVELS - 1; l >= 0; l--) begin
            px = ancestor_rows[int'(x) * LEVELS + l];
            py = ancestor_rows[int'(y) * LEVELS + l];
            if (px != py) begin
                x = px;
                y = py;
            end
        end
        return (x == y) ? x : t_node'(ancestor_rows[int'(x) * LEVELS]);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_node fresh_node();
        t_node n;
        do n = t_node'($urandom_range(1, 65535)); while (is_placed[n]);
        return n;
    endfunction

    function automatic t_node pick_placed();
        return placed[$urandom_range(0, placed.size() - 1)];
    endfunction

    // query operand: an attached node, sometimes the sentinel
    function automatic t_node pick_query_node();
        if ($urandom_range(0, 19) == 0) return '0;
        return pick_placed();
    endfunction

    // one request: optional idle gap, hold valid until accepted, then predict
    task automatic send_request(input logic kind, input t_node na, input t_node nb);
        int       gap;
        t_lca_due due;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {nb, na};
        s_tuser  <= kind;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (kind == lca_pkg::KIND_QUERY) begin
            due.node_a = na;
            due.node_b = nb;
            due.lca    = predict_lca(na, nb);
            lca_due    = {lca_due, due};
        end else begin
            record_attach(na, nb);
            if (na != '0 && !is_placed[na]) begin
                is_placed[na] = 1'b1;
                placed        = {placed, na};
            end
        end
    endtask

    // sender stops until every query answer has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (lca_due.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // small forest on extreme node numbers, sentinel handling, self query,
    // ancestor-of-itself query and nodes in separate trees
    task automatic test_sentinel_and_small_tree();
        send_request(lca_pkg::KIND_ATTACH, 16'hFFFF, 16'h0000);   // root at top number
        send_request(lca_pkg::KIND_ATTACH, 16'h0001, 16'hFFFF);
        send_request(lca_pkg::KIND_ATTACH, 16'hAAAA, 16'h0001);
        send_request(lca_pkg::KIND_ATTACH, 16'h5555, 16'hFFFF);
        send_request(lca_pkg::KIND_ATTACH, 16'h7FFF, 16'h0000);   // second tree
        send_request(lca_pkg::KIND_ATTACH, 16'h8000, 16'h7FFF);
        send_request(lca_pkg::KIND_ATTACH, 16'h0F0F, 16'hAAAA);
        send_request(lca_pkg::KIND_ATTACH, 16'hF0F0, 16'h0F0F);
        send_request(lca_pkg::KIND_ATTACH, 16'h0000, 16'h0001);   // sentinel attach, ignored
        send_request(lca_pkg::KIND_QUERY, 16'hAAAA, 16'h5555);    // common ancestor at the root
        send_request(lca_pkg::KIND_QUERY, 16'h0001, 16'hAAAA);    // one is the ancestor
        send_request(lca_pkg::KIND_QUERY, 16'hAAAA, 16'hAAAA);    // same node
        send_request(lca_pkg::KIND_QUERY, 16'hAAAA, 16'h8000);    // different trees
        send_request(lca_pkg::KIND_QUERY, 16'hFFFF, 16'h0000);    // against the sentinel
        send_request(lca_pkg::KIND_QUERY, 16'h8000, 16'h7FFF);
        send_request(lca_pkg::KIND_QUERY, 16'hF0F0, 16'h5555);
        send_request(lca_pkg::KIND_QUERY, 16'h0001, 16'hF0F0);
        send_request(lca_pkg::KIND_QUERY, 16'hF0F0, 16'h0F0F);
    endtask

    // long chain so that depth differences reach lift level 8,
    // first part with no idling at all, then branches and queries along it
    task automatic test_deep_chain();
        t_node spine [$];
        t_node leaf;
        steady = 1'b1;
        spine = {spine, fresh_node()};
        send_request(lca_pkg::KIND_ATTACH, spine[0], '0);
        for (int i = 1; i < 280; i++) begin
            if (i == 120) steady = 1'b0;
            spine = {spine, fresh_node()};
            send_request(lca_pkg::KIND_ATTACH, spine[i], spine[i - 1]);
        end
        for (int i = 0; i < 40; i++) begin
            if (i % 2 == 0) begin
                leaf = fresh_node();
                send_request(lca_pkg::KIND_ATTACH, leaf,
                             spine[$urandom_range(0, spine.size() - 1)]);
                send_request(lca_pkg::KIND_QUERY, leaf,
                             spine[$urandom_range(0, spine.size() - 1)]);
            end else begin
                send_request(lca_pkg::KIND_QUERY, spine[$urandom_range(0, spine.size() - 1)],
                             spine[$urandom_range(0, spine.size() - 1)]);
            end
        end
    endtask

    // growing forest: attaches under recent or any node, new roots, queries,
    // and ignored sentinel attaches as noise
    task automatic test_random_forest();
        int    sent;
        int    r;
        t_node parent;
        sent = 0;
        while (sent < 720) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                // ignored by the block, any parent number is fine here
                send_request(lca_pkg::KIND_ATTACH, '0, t_node'($urandom_range(0, 65535)));
            end else if (r < 60) begin
                r = $urandom_range(0, 9);
                if (r < 4)
                    parent = placed[placed.size() - 1 - $urandom_range(0, 15)];
                else if (r < 9)
                    parent = pick_placed();
                else
                    parent = '0;
                send_request(lca_pkg::KIND_ATTACH, fresh_node(), parent);
                sent++;
            end else begin
                send_request(lca_pkg::KIND_QUERY, pick_query_node(), pick_query_node());
                sent++;
            end
        end
    endtask

    // attached nodes moved again: under another node, under themselves or to
    // the root, which can leave stale rows and loops; lifts stay bounded
    task automatic test_rewired_tree();
        int    r;
        t_node moved;
        for (int i = 0; i < 220; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                moved = pick_placed();
                r = $urandom_range(0, 3);
                if (r < 2)
                    send_request(lca_pkg::KIND_ATTACH, moved, pick_placed());
                else if (r == 2)
                    send_request(lca_pkg::KIND_ATTACH, moved, moved);
                else
                    send_request(lca_pkg::KIND_ATTACH, moved, '0);
            end else if (r < 50) begin
                send_request(lca_pkg::KIND_ATTACH, fresh_node(), pick_placed());
            end else begin
                send_request(lca_pkg::KIND_QUERY, pick_query_node(), pick_query_node());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    function automatic void flag_fault(input string what);
        fault_count++;
        if (fault_count <= 10) $display("mismatch: %s", what);
    endfunction

    // ready pattern: runs of ready and stalls of random length, no new stall while steady
    initial begin
        forever begin
            @(posedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(0, 8);
            end else begin
                m_tready   <= 1'b0;
                ready_hold = pick_gap();
            end
        end
    end

    // every accepted result against the oldest pending query
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (lca_due.size() == 0) begin
                flag_fault($sformatf("ancestor %h with no query pending", m_tdata));
            end else begin
                got_due = lca_due.pop_front();
                if (m_tdata !== got_due.lca)
                    flag_fault($sformatf("query %h %h: expected %h, got %h",
                                         got_due.node_a, got_due.node_b, got_due.lca, m_tdata));
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        int waited;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sentinel_and_small_tree();
        test_deep_chain();
        hold_until_drained();
        test_random_forest();
        test_rewired_tree();

        // wait out the answers still in flight and the last attach
        s_tvalid <= 1'b0;
        waited = 0;
        while (lca_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (lca_due.size() != 0)
            flag_fault($sformatf("%0d query answers never arrived", lca_due.size()));

        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hang guard
    initial begin
        #RUN_LIMIT;
        $display("simulation failed");
        $finish;
    end

endmodule
